// File: rtl/gaze_dwell_region_detector_core_assert.svh
// ----------------------------------------------------------------------------
// gaze dwell region detector assertion macros
// shared property wrappers for the detector core
// ----------------------------------------------------------------------------
`ifndef GAZE_DWELL_REGION_DETECTOR_CORE_ASSERT_SVH
`define GAZE_DWELL_REGION_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define GDRD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while reset is held
`define GDRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gdrd_pkg.sv
// ----------------------------------------------------------------------------
// gdrd_pkg
// types, codes and constants of the gaze dwell region detector
// ----------------------------------------------------------------------------
package gdrd_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_SLEEPING  = 2'd0,
        PH_INITIATED = 2'd1,
        PH_FINISHED  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_STOP  = 2'd1,
        EV_ABORT = 2'd2
    } t_event_kind;

    // request opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REGION = 1'b1;

    // configuration register indexes
    localparam int          CFG_IDX_W          = 2;
    localparam logic [1:0]  REG_REGION_COUNT   = 2'd0;
    localparam logic [1:0]  REG_START_DWELL    = 2'd1;
    localparam logic [1:0]  REG_COMPLETE_DWELL = 2'd2;

    // start dwell defaults to 0.33 of the default completion dwell
    localparam logic [31:0] COMPLETE_DWELL_RESET = 32'd1000;
    localparam logic [31:0] START_DWELL_RESET    = 32'd330;

    // slots reachable through the 4-bit slot field
    localparam int MAX_SLOTS = 16;

    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// File: rtl/gdrd_ram.sv
// ----------------------------------------------------------------------------
// gdrd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module gdrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [gdrd_pkg::addr_width(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [gdrd_pkg::addr_width(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/gaze_dwell_region_detector_core.sv
// ----------------------------------------------------------------------------
// gaze_dwell_region_detector_core
// dwell-time selection of rectangular screen regions from gaze samples
// ----------------------------------------------------------------------------
// usage
//   requests enter on start while busy is low; op selects a region write
//   (rectangle into one slot, clears that slot's gaze state) or a gaze sample
//   region writes finish in the accepting cycle and leave busy low
//   a valid gaze sample walks the active slots, one slot per cycle, through
//   the rectangle and dwell-start rams (one read port each, registered reads)
//   events leave on o_event_* with o_event_valid high for one cycle each:
//   starts, then stops, then aborts, each group in slot order, o_last_event
//   marks the final one of the sample
//   at most 16 slots are active; after the walk the events are issued one
//   per cycle, and a sample with no event still passes once through emit;
//   busy stays high through walk and emit, so samples do not overlap
//   invalid samples and samples with no active slot are taken and dropped
//   the receiver cannot stall; events are never held back
//   reset (synchronous, active low) returns all slots to sleeping and not
//   gazed and restores the register defaults; rectangles are not cleared
//   the user, not the block, ensures configuration is written only while idle
// ----------------------------------------------------------------------------
module gaze_dwell_region_detector_core #(
    parameter int REGIONS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [gdrd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                  i_cfg_data,
    // request channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_op,
    input  logic                         i_sample_valid,
    input  logic [15:0]                  i_gaze_x,
    input  logic [15:0]                  i_gaze_y,
    input  logic [31:0]                  i_timestamp_ms,
    input  logic [3:0]                   i_region_slot,
    input  logic [15:0]                  i_rect_left,
    input  logic [15:0]                  i_rect_top,
    input  logic [15:0]                  i_rect_right,
    input  logic [15:0]                  i_rect_bottom,
    // event channel
    output logic                         o_event_valid,
    output gdrd_pkg::t_event_kind        o_event_kind,
    output logic [3:0]                   o_event_region,
    output logic                         o_last_event
);

    import gdrd_pkg::*;

    // slots that can be stored and addressed
    localparam int         SLOTS     = (REGIONS < MAX_SLOTS) ? REGIONS : MAX_SLOTS;
    localparam int         IDX_W     = addr_width(SLOTS);
    localparam logic [4:0] SLOTS_CNT = 5'(SLOTS);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [4:0]  r_count;
    logic [31:0] r_start_ms;
    logic [31:0] r_comp_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_start_ms <= START_DWELL_RESET;
            r_comp_ms  <= COMPLETE_DWELL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_REGION_COUNT:   r_count    <= i_cfg_data[4:0];
                REG_START_DWELL:    r_start_ms <= i_cfg_data;
                REG_COMPLETE_DWELL: r_comp_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // number of slots walked per sample
    logic [4:0] active_cnt;
    assign active_cnt = (r_count > SLOTS_CNT) ? SLOTS_CNT : r_count;

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic accept;
    logic accept_region;
    logic accept_sample;
    logic region_in_range;

    assign busy            = (r_state != S_IDLE);
    assign accept          = start && !busy;
    assign region_in_range = ({1'b0, i_region_slot} < SLOTS_CNT);
    assign accept_region   = accept && (i_op == OP_REGION) && region_in_range;
    // a sample only starts a walk when it is valid and some slot is active
    assign accept_sample   = accept && (i_op == OP_SAMPLE) && i_sample_valid
                             && (active_cnt != 5'd0);

    // latched sample
    logic [15:0] r_gx;
    logic [15:0] r_gy;
    logic [31:0] r_ts;

    always_ff @(posedge i_clk) begin
        if (accept_sample) begin
            r_gx <= i_gaze_x;
            r_gy <= i_gaze_y;
            r_ts <= i_timestamp_ms;
        end
    end

    // ------------------------------------------------------------------
    // slot walk index and ram read side
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] r_idx;
    logic             last_slot;
    logic             scan_en;
    logic             emit_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    // r_idx is the slot whose ram data is on the read ports
    assign last_slot = ((5'(r_idx) + 5'd1) == active_cnt);
    assign rd_en     = accept_sample || (scan_en && !last_slot);
    assign rd_addr   = accept_sample ? '0 : (r_idx + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (accept_sample) begin
            r_idx <= '0;
        end else if (scan_en && !last_slot) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // rectangle store: {bottom, right, top, left}
    logic [63:0] rect_q;
    logic [31:0] dst_q;
    logic        dst_we;

    gdrd_ram #(
        .WIDTH (64),
        .DEPTH (SLOTS)
    ) u_rect_ram (
        .i_clk   (i_clk),
        .i_we    (accept_region),
        .i_waddr (IDX_W'(i_region_slot)),
        .i_wdata ({i_rect_bottom, i_rect_right, i_rect_top, i_rect_left}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rect_q)
    );

    // dwell start time store, written when a slot becomes gazed
    gdrd_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_dwell_ram (
        .i_clk   (i_clk),
        .i_we    (dst_we),
        .i_waddr (r_idx),
        .i_wdata (r_ts),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (dst_q)
    );

    // ------------------------------------------------------------------
    // per-slot gaze state (reset to sleeping, not gazed)
    // ------------------------------------------------------------------
    logic [SLOTS-1:0] r_gazed;
    t_phase           r_phase [SLOTS];

    logic   cur_gazed;
    t_phase cur_phase;
    logic   in_rect;
    logic [31:0] dwell;
    logic   dwell_ge_start;
    logic   dwell_lt_comp;
    logic   upd_gazed;
    t_phase upd_phase;
    logic   ev_start;
    logic   ev_stop;
    logic   ev_abort;

    assign cur_gazed = r_gazed[r_idx];
    assign cur_phase = r_phase[r_idx];

    // inclusive edges; an inverted rectangle holds no point
    assign in_rect = (r_gx >= rect_q[15:0])  && (r_gx <= rect_q[47:32])
                  && (r_gy >= rect_q[31:16]) && (r_gy <= rect_q[63:48]);

    // wrapping dwell
    assign dwell          = r_ts - dst_q;
    assign dwell_ge_start = (dwell >= r_start_ms);
    assign dwell_lt_comp  = (dwell < r_comp_ms);

    always_comb begin
        upd_gazed = cur_gazed;
        upd_phase = cur_phase;
        ev_start  = 1'b0;
        ev_stop   = 1'b0;
        ev_abort  = 1'b0;
        dst_we    = 1'b0;
        if (in_rect) begin
            if (cur_gazed) begin
                if (cur_phase == PH_SLEEPING && dwell_ge_start && dwell_lt_comp) begin
                    upd_phase = PH_INITIATED;
                    ev_start  = 1'b1;
                end else if (cur_phase == PH_INITIATED && !dwell_lt_comp) begin
                    upd_phase = PH_FINISHED;
                    ev_stop   = 1'b1;
                end
            end else begin
                // first gazed sample opens the dwell
                upd_gazed = 1'b1;
                dst_we    = scan_en;
            end
        end else if (cur_gazed) begin
            // leaving an initiated region aborts it
            ev_abort  = (cur_phase == PH_INITIATED);
            upd_gazed = 1'b0;
            upd_phase = PH_SLEEPING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gazed <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_phase[i] <= PH_SLEEPING;
            end
        end else if (accept_region) begin
            r_gazed[IDX_W'(i_region_slot)] <= 1'b0;
            r_phase[IDX_W'(i_region_slot)] <= PH_SLEEPING;
        end else if (scan_en) begin
            r_gazed[r_idx] <= upd_gazed;
            r_phase[r_idx] <= upd_phase;
        end
    end

    // ------------------------------------------------------------------
    // event masks: one bit per slot for each event group
    // ------------------------------------------------------------------
    logic [SLOTS-1:0] r_start_mask;
    logic [SLOTS-1:0] r_stop_mask;
    logic [SLOTS-1:0] r_abort_mask;

    logic [SLOTS-1:0] sel_mask;
    logic [SLOTS-1:0] sel_low;
    t_event_kind      sel_kind;
    logic [IDX_W-1:0] emit_idx;
    logic             emit_any;
    logic             emit_last;

    assign emit_any = (|r_start_mask) || (|r_stop_mask) || (|r_abort_mask);

    // pick the lowest pending slot of the first non-empty group
    always_comb begin
        if (|r_start_mask) begin
            sel_mask  = r_start_mask;
            sel_kind  = EV_START;
        end else if (|r_stop_mask) begin
            sel_mask  = r_stop_mask;
            sel_kind  = EV_STOP;
        end else begin
            sel_mask  = r_abort_mask;
            sel_kind  = EV_ABORT;
        end
        sel_low  = sel_mask & (~sel_mask + 1'b1);
        emit_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (sel_low[i]) begin
                emit_idx = emit_idx | IDX_W'(i);
            end
        end
        case (sel_kind)
            EV_START: emit_last = ((sel_mask & ~sel_low) == '0)
                                  && (r_stop_mask == '0) && (r_abort_mask == '0);
            EV_STOP:  emit_last = ((sel_mask & ~sel_low) == '0) && (r_abort_mask == '0);
            default:  emit_last = ((sel_mask & ~sel_low) == '0);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_mask <= '0;
            r_stop_mask  <= '0;
            r_abort_mask <= '0;
        end else if (accept_sample) begin
            r_start_mask <= '0;
            r_stop_mask  <= '0;
            r_abort_mask <= '0;
        end else if (scan_en) begin
            if (ev_start) r_start_mask[r_idx] <= 1'b1;
            if (ev_stop)  r_stop_mask[r_idx]  <= 1'b1;
            if (ev_abort) r_abort_mask[r_idx] <= 1'b1;
        end else if (emit_en) begin
            case (sel_kind)
                EV_START: r_start_mask <= r_start_mask & ~sel_low;
                EV_STOP:  r_stop_mask  <= r_stop_mask & ~sel_low;
                default:  r_abort_mask <= r_abort_mask & ~sel_low;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept_sample) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (last_slot) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!emit_any || emit_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        scan_en = 1'b0;
        emit_en = 1'b0;
        case (r_state)
            S_SCAN:  scan_en = 1'b1;
            S_EMIT:  emit_en = emit_any;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // event output register
    // ------------------------------------------------------------------
    logic        r_ev_valid;
    t_event_kind r_ev_kind;
    logic [3:0]  r_ev_region;
    logic        r_ev_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else begin
            r_ev_valid <= emit_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_en) begin
            r_ev_kind   <= sel_kind;
            r_ev_region <= 4'(emit_idx);
            r_ev_last   <= emit_last;
        end
    end

    assign o_event_valid  = r_ev_valid;
    assign o_event_kind   = r_ev_kind;
    assign o_event_region = r_ev_region;
    assign o_last_event   = r_ev_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`include "gaze_dwell_region_detector_core_assert.svh"

    `GDRD_ASSERT_IMPLIES(a_event_from_emit, i_clk, i_rst_n, r_ev_valid,
        $past(r_state == S_EMIT), "event strobe outside emit")
    `GDRD_ASSERT_NEXT(a_last_ends_sample, i_clk, i_rst_n, (emit_en && emit_last),
        (r_state == S_IDLE && r_ev_valid && r_ev_last),
        "last event did not close the sample")
    `GDRD_ASSERT_IMPLIES(a_masks_disjoint, i_clk, i_rst_n, 1'b1,
        (((r_start_mask & r_stop_mask) | (r_start_mask & r_abort_mask)
          | (r_stop_mask & r_abort_mask)) == '0), "slot in two event groups")
    `GDRD_ASSERT_IMPLIES(a_phase_needs_gaze, i_clk, i_rst_n, scan_en,
        (cur_phase == PH_SLEEPING || cur_gazed), "active phase on slot that is not gazed")

endmodule

// File: tb/tb_gaze_dwell_region_detector_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gaze_dwell_region_detector_core
// self-checking bench for the dwell detector: directed dwell scenarios, then
// random gaze tracks over several register settings; an in-bench model of the
// slot phases predicts every event, a monitor checks them in order
// ----------------------------------------------------------------------------
module tb_gaze_dwell_region_detector_core;
    import gdrd_pkg::*;

    // chance in a hundred that the sender holds off a request before offering it
    localparam int IDLE_PCT      = 19;
    // one full slot walk plus emit margin, used as the quiet time before config
    localparam int SETTLE_CYCLES = MAX_SLOTS + 8;
    // worst request is a walk of 16 slots with 16 events, plus sender gaps
    // and the settle pause, so this leaves a wide margin
    localparam int STALL_LIMIT   = 2000;

    typedef struct packed {
        t_event_kind kind;
        logic [3:0]  region;
        logic        last;
    } t_gaze_event;

    typedef struct {
        logic        op;
        logic        valid;
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] ts;
        logic [3:0]  slot;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
    } t_gaze_request;

    // dut ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]          i_cfg_data;
    logic                 start;
    logic                 busy;
    logic                 i_op;
    logic                 i_sample_valid;
    logic [15:0]          i_gaze_x;
    logic [15:0]          i_gaze_y;
    logic [31:0]          i_timestamp_ms;
    logic [3:0]           i_region_slot;
    logic [15:0]          i_rect_left;
    logic [15:0]          i_rect_top;
    logic [15:0]          i_rect_right;
    logic [15:0]          i_rect_bottom;
    logic                 o_event_valid;
    t_event_kind          o_event_kind;
    logic [3:0]           o_event_region;
    logic                 o_last_event;

    // model of the slot store and the registers
    logic [15:0] slot_left   [MAX_SLOTS];
    logic [15:0] slot_top    [MAX_SLOTS];
    logic [15:0] slot_right  [MAX_SLOTS];
    logic [15:0] slot_bottom [MAX_SLOTS];
    logic        slot_gazed  [MAX_SLOTS];
    t_phase      slot_phase  [MAX_SLOTS];
    logic [31:0] slot_entry_ms [MAX_SLOTS];
    logic [4:0]  cfg_region_count = 5'd0;
    logic [31:0] cfg_start_ms     = START_DWELL_RESET;
    logic [31:0] cfg_complete_ms  = COMPLETE_DWELL_RESET;

    t_gaze_event pending_events [$];
    t_gaze_event due_event;
    int          mismatch_count = 0;
    int          stall_cycles   = 0;
    bit          sender_idles   = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    gaze_dwell_region_detector_core #(
        .REGIONS        (MAX_SLOTS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_sample_valid (i_sample_valid),
        .i_gaze_x       (i_gaze_x),
        .i_gaze_y       (i_gaze_y),
        .i_timestamp_ms (i_timestamp_ms),
        .i_region_slot  (i_region_slot),
        .i_rect_left    (i_rect_left),
        .i_rect_top     (i_rect_top),
        .i_rect_right   (i_rect_right),
        .i_rect_bottom  (i_rect_bottom),
        .o_event_valid  (o_event_valid),
        .o_event_kind   (o_event_kind),
        .o_event_region (o_event_region),
        .o_last_event   (o_last_event)
    );

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------

    // slots taking part, the count register saturates at the slot store size
    function automatic int active_slots();
        return (cfg_region_count > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_region_count);
    endfunction

    // one event per set bit, ascending slot order; the final event of the
    // sample carries the last flag
    function automatic void queue_event_group(input logic [15:0] mask,
                                              input t_event_kind kind,
                                              inout int events_left);
        t_gaze_event ev;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            if (mask[s]) begin
                events_left--;
                ev.kind   = kind;
                ev.region = 4'(s);
                ev.last   = (events_left == 0);
                pending_events = {pending_events, ev};
            end
        end
    endfunction

    // walk the active slots for one valid sample and queue its events
    function automatic void predict_gaze_events(input logic [15:0] gx, gy,
                                                input logic [31:0] ts);
        logic [15:0] start_mask;
        logic [15:0] stop_mask;
        logic [15:0] abort_mask;
        logic [31:0] dwell;
        int          events_left;
        start_mask = '0;
        stop_mask  = '0;
        abort_mask = '0;
        for (int s = 0; s < active_slots(); s++) begin
            // inclusive edges, an inverted box holds no point
            if (gx >= slot_left[s] && gx <= slot_right[s] &&
                    gy >= slot_top[s] && gy <= slot_bottom[s]) begin
                if (slot_gazed[s]) begin
                    dwell = ts - slot_entry_ms[s];  // wraps modulo 2^32
                    if (slot_phase[s] == PH_SLEEPING && dwell >= cfg_start_ms &&
                            dwell < cfg_complete_ms) begin
                        slot_phase[s] = PH_INITIATED;
                        start_mask[s] = 1'b1;
                    end else if (slot_phase[s] == PH_INITIATED &&
                                 dwell >= cfg_complete_ms) begin
                        slot_phase[s] = PH_FINISHED;
                        stop_mask[s]  = 1'b1;
                    end
                end else begin
                    slot_gazed[s]    = 1'b1;
                    slot_entry_ms[s] = ts;
                end
            end else if (slot_gazed[s]) begin
                if (slot_phase[s] == PH_INITIATED) begin
                    abort_mask[s] = 1'b1;
                end
                slot_gazed[s] = 1'b0;
                slot_phase[s] = PH_SLEEPING;
            end
        end
        events_left = $countones(start_mask) + $countones(stop_mask) +
                      $countones(abort_mask);
        queue_event_group(start_mask, EV_START, events_left);
        queue_event_group(stop_mask, EV_STOP, events_left);
        queue_event_group(abort_mask, EV_ABORT, events_left);
    endfunction

    // ------------------------------------------------------------------------
    // request and config drivers
    // ------------------------------------------------------------------------

    // offer one request and hold it until taken; start is left high so that a
    // following request goes out back to back, callers that stop sending
    // lower it in the same step
    task automatic send_request(input t_gaze_request req);
        if (sender_idles && $urandom_range(99, 0) < IDLE_PCT) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < IDLE_PCT);
        end
        start          <= 1'b1;
        i_op           <= req.op;
        i_sample_valid <= req.valid;
        i_gaze_x       <= req.x;
        i_gaze_y       <= req.y;
        i_timestamp_ms <= req.ts;
        i_region_slot  <= req.slot;
        i_rect_left    <= req.left;
        i_rect_top     <= req.top;
        i_rect_right   <= req.right;
        i_rect_bottom  <= req.bottom;
        do @(posedge i_clk); while (busy !== 1'b0);
        // request taken at this edge, update the model
        if (req.op == OP_REGION) begin
            slot_left[req.slot]   = req.left;
            slot_top[req.slot]    = req.top;
            slot_right[req.slot]  = req.right;
            slot_bottom[req.slot] = req.bottom;
            slot_gazed[req.slot]  = 1'b0;
            slot_phase[req.slot]  = PH_SLEEPING;
        end else if (req.valid) begin
            predict_gaze_events(req.x, req.y, req.ts);
        end
    endtask

    // gaze sample, the region fields carry noise
    task automatic send_gaze(input logic [15:0] x, y, input logic [31:0] ts,
                             input logic valid);
        t_gaze_request req;
        req.op     = OP_SAMPLE;
        req.valid  = valid;
        req.x      = x;
        req.y      = y;
        req.ts     = ts;
        req.slot   = 4'($urandom());
        req.left   = 16'($urandom());
        req.top    = 16'($urandom());
        req.right  = 16'($urandom());
        req.bottom = 16'($urandom());
        send_request(req);
    endtask

    // region write, the sample fields and the valid flag carry noise
    task automatic send_region(input logic [3:0] slot,
                               input logic [15:0] left, top, right, bottom);
        t_gaze_request req;
        req.op     = OP_REGION;
        req.valid  = 1'($urandom());
        req.x      = 16'($urandom());
        req.y      = 16'($urandom());
        req.ts     = $urandom();
        req.slot   = slot;
        req.left   = left;
        req.top    = top;
        req.right  = right;
        req.bottom = bottom;
        send_request(req);
    endtask

    // stop requesting, let every expected event come out, then let the slot
    // walk of a sample with no events run out as well
    task automatic drain_events();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_events.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write enable is left high, callers lower it after their last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_REGION_COUNT:   cfg_region_count = data[4:0];
            REG_START_DWELL:    cfg_start_ms     = data;
            REG_COMPLETE_DWELL: cfg_complete_ms  = data;
            default: ;
        endcase
    endtask

    task automatic apply_dwell_config(input logic [4:0] count,
                                      input logic [31:0] start_ms, complete_ms);
        drain_events();
        cfg_write(REG_REGION_COUNT, {27'd0, count});
        cfg_write(REG_START_DWELL, start_ms);
        cfg_write(REG_COMPLETE_DWELL, complete_ms);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // register defaults: start at 330 ms, complete at 1000 ms, across the
    // timestamp wrap; a sample with no active slot; an inverted box
    task automatic test_default_dwell();
        logic [31:0] t0;
        t0 = 32'hFFFF_FF00;
        send_region(4'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);  // full screen
        send_region(4'd1, 16'h9000, 16'h0000, 16'h1000, 16'hFFFF);  // left past right
        send_gaze(16'h8000, 16'h8000, t0, 1'b1);                    // count still zero
        drain_events();
        cfg_write(REG_REGION_COUNT, 32'd2);
        i_cfg_we <= 1'b0;
        send_gaze(16'h0000, 16'h0000, t0, 1'b1);                    // enter slot 0
        send_gaze(16'hFFFF, 16'hFFFF, t0 + 32'd329, 1'b1);          // one short of start
        send_gaze(16'h8000, 16'h0000, t0 + 32'd330, 1'b1);          // start, past the wrap
        send_gaze(16'h0000, 16'hFFFF, t0 + 32'd999, 1'b1);
        send_gaze(16'hFFFF, 16'h0000, t0 + 32'd1000, 1'b1);         // stop
        send_gaze(16'h1234, 16'h5678, t0 + 32'd1001, 1'b0);         // invalid, ignored
        send_gaze(16'h4000, 16'h4000, t0 + 32'd5000, 1'b1);         // stays finished
    endtask

    // all sixteen slots on one box, count above the store size, dwell
    // thresholds at their extremes: sixteen starts, stops and aborts at once
    task automatic test_all_slots_saturated();
        logic [31:0] t0;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            send_region(4'(s), 16'h1000, 16'h1000, 16'hF000, 16'hF000);
        end
        apply_dwell_config(5'd31, 32'd0, 32'hFFFF_FFFF);
        t0 = $urandom();
        send_gaze(16'h1000, 16'hF000, t0, 1'b1);                    // corner, enter all
        send_gaze(16'hF000, 16'h1000, t0, 1'b1);                    // zero dwell starts
        send_gaze(16'h8000, 16'h8000, t0 + 32'hFFFF_FFFF, 1'b1);    // all stop
        send_gaze(16'h8000, 16'h8000, t0 + 32'd3, 1'b1);            // finished, quiet
        send_gaze(16'h0000, 16'h0000, t0 + 32'd4, 1'b1);            // leave, no abort
        send_gaze(16'h8000, 16'h8000, t0 + 32'd10, 1'b1);
        send_gaze(16'h8000, 16'h8000, t0 + 32'd11, 1'b1);
        send_gaze(16'hFFFF, 16'hFFFF, t0 + 32'd12, 1'b1);           // all abort
    endtask

    // one sample that starts, stops and aborts, checks group order; then a
    // rewrite of an initiated slot drops it back without an abort
    task automatic test_event_order();
        logic [31:0] t0;
        apply_dwell_config(5'd3, 32'd10, 32'd100);
        send_region(4'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_region(4'd1, 16'h0000, 16'h0000, 16'h8000, 16'hFFFF);
        send_region(4'd2, 16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF);
        t0 = $urandom();
        send_gaze(16'h1000, 16'h0100, t0, 1'b1);
        send_gaze(16'h1000, 16'h0100, t0 + 32'd20, 1'b1);
        send_gaze(16'h8000, 16'h8000, t0 + 32'd90, 1'b1);           // shared edge
        send_gaze(16'hF000, 16'h2000, t0 + 32'd100, 1'b1);
        send_region(4'd2, 16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_gaze(16'h0000, 16'h0000, t0 + 32'd120, 1'b1);
    endtask

    // start threshold not below completion: no start, hence no stop
    task automatic test_dwell_extremes();
        logic [31:0] t0;
        apply_dwell_config(5'd3, 32'hFFFF_FFFF, 32'd0);
        t0 = $urandom();
        send_gaze(16'hF000, 16'h2000, t0, 1'b1);
        send_gaze(16'hF000, 16'h2000, t0 + 32'h7FFF_FFFF, 1'b1);
        send_gaze(16'hF000, 16'h2000, t0 + 32'hFFFF_FFFE, 1'b1);
    endtask

    // random gaze tracks: the gaze mostly lingers in one active box with
    // small time steps so dwell crosses both thresholds; the rest is random
    // points, time jumps, invalid samples and box rewrites
    task automatic test_random_tracks(input int items, input logic [4:0] count,
                                      input logic [31:0] start_ms, complete_ms,
                                      input bit idles);
        int          active;
        int          focus;
        int          step_max;
        int          pick;
        logic [31:0] now_ms;
        logic [15:0] x, y, l, t, r, b;
        apply_dwell_config(count, start_ms, complete_ms);
        sender_idles = idles;
        active   = active_slots();
        now_ms   = $urandom();
        step_max = (complete_ms < 400) ? int'(complete_ms) / 2 + 5 : 200;
        focus    = $urandom_range(active - 1, 0);
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(99, 0);
            if (pick < 7) begin
                if ($urandom_range(2, 0) == 0) begin
                    // arbitrary edges, often inverted
                    l = 16'($urandom());
                    t = 16'($urandom());
                    r = 16'($urandom());
                    b = 16'($urandom());
                end else begin
                    l = 16'($urandom_range(16'h9FFF, 0));
                    t = 16'($urandom_range(16'h9FFF, 0));
                    r = l + 16'($urandom_range(16'h6000, 16'h1000));
                    b = t + 16'($urandom_range(16'h6000, 16'h1000));
                end
                send_region(4'($urandom()), l, t, r, b);
            end else begin
                if ($urandom_range(99, 0) < 20) begin
                    focus = $urandom_range(active - 1, 0);
                end
                now_ms = now_ms + $urandom_range(step_max, 0);
                if (pick < 80 && slot_left[focus] <= slot_right[focus] &&
                        slot_top[focus] <= slot_bottom[focus]) begin
                    x = 16'($urandom_range(slot_right[focus], slot_left[focus]));
                    y = 16'($urandom_range(slot_bottom[focus], slot_top[focus]));
                end else begin
                    x = 16'($urandom());
                    y = 16'($urandom());
                end
                send_gaze(x, y, (pick >= 95) ? $urandom() : now_ms,
                          $urandom_range(99, 0) >= 8);
            end
        end
        sender_idles = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // event monitor: every strobe is taken, compared with the oldest expected
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_event_valid === 1'b1) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event: kind %0d region %0d last %0b",
                       o_event_kind, o_event_region, o_last_event);
                mismatch_count++;
            end else begin
                due_event = pending_events.pop_front();
                if (o_event_kind !== due_event.kind) begin
                    $error("event_kind: expected %0d, actual %0d",
                           due_event.kind, o_event_kind);
                    mismatch_count++;
                end
                if (o_event_region !== due_event.region) begin
                    $error("event_region: expected %0d, actual %0d",
                           due_event.region, o_event_region);
                    mismatch_count++;
                end
                if (o_last_event !== due_event.last) begin
                    $error("last_event: expected %0b, actual %0b",
                           due_event.last, o_last_event);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: cycles with neither a request taken nor an event out
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_event_valid === 1'b1) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("gaze_dwell_region_detector_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] track_start_ms;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            slot_gazed[s] = 1'b0;
            slot_phase[s] = PH_SLEEPING;
        end
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= REG_REGION_COUNT;
        i_cfg_data     <= '0;
        start          <= 1'b0;
        i_op           <= OP_SAMPLE;
        i_sample_valid <= 1'b0;
        i_gaze_x       <= '0;
        i_gaze_y       <= '0;
        i_timestamp_ms <= '0;
        i_region_slot  <= '0;
        i_rect_left    <= '0;
        i_rect_top     <= '0;
        i_rect_right   <= '0;
        i_rect_bottom  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_dwell();
        test_all_slots_saturated();
        test_event_order();
        test_dwell_extremes();

        // random phases, every slot has a box by now
        test_random_tracks(60, 5'd16, 32'd20, 32'd120, 1'b1);
        test_random_tracks(50, 5'd31, 32'd0, 32'd60, 1'b0);    // no sender gaps
        test_random_tracks(30, 5'd5, 32'd40, 32'd40, 1'b1);    // start equals complete
        test_random_tracks(40, 5'd1, 32'd10, 32'd50, 1'b1);
        track_start_ms = $urandom_range(50, 0);
        test_random_tracks(84, 5'($urandom_range(15, 2)), track_start_ms,
                           track_start_ms + 32'($urandom_range(150, 1)), 1'b1);

        drain_events();
        if (mismatch_count == 0) begin
            $display("gaze_dwell_region_detector_core: match");
        end else begin
            $display("gaze_dwell_region_detector_core: mismatch");
        end
        $finish;
    end

endmodule
